// ===== rtl/dot_pkg.sv =====
// Package for the device observation table: sizes, status codes and the
// payload and table record layouts. No dependencies.
`default_nettype none

package dot_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_UPDATED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_REJECTED = 2'd2,
    ST_CLEARED  = 2'd3
  } status_t;

  // Observation fields, last field (mac) in the lowest bits.
  typedef struct packed {
    logic [6:0]         pad;
    logic signed [31:0] longitude;
    logic signed [30:0] latitude;
    logic [31:0]        gps_utc;
    logic               gps_valid;
    logic [31:0]        now_ms;
    logic [7:0]         encryption;
    logic [7:0]         channel;
    logic signed [7:0]  rssi;
    logic               net_type;
    logic [47:0]        mac;
  } obs_t;

  // Result fields carried in tdata, last field in the lowest bits.
  typedef struct packed {
    logic              pad;
    logic [9:0]        ble_devices;
    logic [9:0]        wifi_devices;
    logic [9:0]        total_devices;
    logic signed [7:0] best_signal;
    logic [15:0]       hits;
    logic [8:0]        entry_index;
  } res_t;

  // One table slot apart from its MAC, which lives in the search memory.
  typedef struct packed {
    logic              kind_bit;
    logic signed [7:0] best_rssi;
    logic signed [7:0] last_rssi;
    logic [7:0]        channel;
    logic [7:0]        auth_mode;
    logic [31:0]       first_ms;
    logic [31:0]       last_ms;
    logic [31:0]       first_utc;
    logic [15:0]       hit_count;
    logic              has_fix;
    logic [63:0]       position;
  } rec_t;

endpackage

`default_nettype wire

// ===== rtl/device_observation_table.sv =====
// Device observation table: a sequencer that walks the MAC memory with one
// comparator, then inserts or updates the device record.
// A clear goes straight to the finishing step; an observation takes longer as
// more devices are stored, set by the single MAC compare fed by one read of the
// MAC memory per cycle. One item at a time: the next transaction is taken once
// the result is loaded into the output register, later while a result waits.
// Reset clears the sequencer and the device counts; the fill count marks the
// valid slots, so the memories need no clearing pass.
`default_nettype none

module device_observation_table
  import dot_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [207:0] s_tdata,  // mac, net_type, rssi, channel, encryption, now_ms,
                                      // gps_valid, gps_utc, latitude, longitude
  input  wire logic         s_tuser,  // kind
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [63:0]       m_tdata,  // entry_index, hits, best_signal, total_devices,
                                      // wifi_devices, ble_devices
  output logic [1:0]        m_tuser   // status
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_UPD  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t            state;
  obs_t              obs;
  logic [CNT_W-1:0]  issue_idx;
  logic              pend;
  logic [IDX_W-1:0]  pend_idx;
  logic [IDX_W-1:0]  hit_idx;
  logic [CNT_W-1:0]  used_entries;
  logic [CNT_W-1:0]  wifi_total;
  status_t           res_status;
  logic [IDX_W-1:0]  res_index;
  logic [15:0]       res_hits;
  logic signed [7:0] res_best;
  res_t              out_q;
  status_t           out_status;

  logic [47:0]       mac_q;
  rec_t              rec_q;
  rec_t              rec_new;
  logic              match;
  logic              more;
  logic              full;
  logic              we_ins;
  logic              we_rec;
  logic [IDX_W-1:0]  rec_waddr;

  assign match     = pend && (mac_q == obs.mac);
  assign more      = issue_idx < used_entries;
  assign full      = used_entries >= CNT_W'(TABLE_DEPTH);
  assign we_ins    = (state == S_SCAN) && !match && !more && !full;
  assign we_rec    = we_ins || (state == S_UPD);
  assign rec_waddr = (state == S_UPD) ? hit_idx : used_entries[IDX_W-1:0];

  dot_ram #(.WIDTH(48), .DEPTH(TABLE_DEPTH)) u_mac_ram (
    .clk   (clk),
    .we    (we_ins),
    .waddr (used_entries[IDX_W-1:0]),
    .wdata (obs.mac),
    .raddr (issue_idx[IDX_W-1:0]),
    .rdata (mac_q)
  );

  dot_ram #(.WIDTH($bits(rec_t)), .DEPTH(TABLE_DEPTH)) u_rec_ram (
    .clk   (clk),
    .we    (we_rec),
    .waddr (rec_waddr),
    .wdata (rec_new),
    .raddr (pend_idx),
    .rdata (rec_q)
  );

  dot_record_update u_update (
    .insert  (state != S_UPD),
    .obs     (obs),
    .rec_old (rec_q),
    .rec_new (rec_new)
  );

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pend         <= 1'b0;
      used_entries <= '0;
      wifi_total   <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            obs       <= obs_t'(s_tdata);
            issue_idx <= '0;
            pend      <= 1'b0;
            if (s_tuser) begin
              used_entries <= '0;
              wifi_total   <= '0;
              res_status   <= ST_CLEARED;
              res_index    <= '0;
              res_hits     <= '0;
              res_best     <= '0;
              state        <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (match) begin
            hit_idx <= pend_idx;
            state   <= S_UPD;
          end else if (more) begin
            pend      <= 1'b1;
            pend_idx  <= issue_idx[IDX_W-1:0];
            issue_idx <= issue_idx + CNT_W'(1);
          end else begin
            pend <= 1'b0;
            if (full) begin
              res_status <= ST_REJECTED;
              res_index  <= '0;
              res_hits   <= '0;
              res_best   <= '0;
            end else begin
              used_entries <= used_entries + CNT_W'(1);
              if (!obs.net_type) begin
                wifi_total <= wifi_total + CNT_W'(1);
              end
              res_status <= ST_INSERTED;
              res_index  <= used_entries[IDX_W-1:0];
              res_hits   <= 16'd1;
              res_best   <= obs.rssi;
            end
            state <= S_DONE;
          end
        end
        S_UPD: begin
          pend       <= 1'b0;
          res_status <= ST_UPDATED;
          res_index  <= hit_idx;
          res_hits   <= rec_new.hit_count;
          res_best   <= rec_new.best_rssi;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid                <= 1'b1;
            out_status              <= res_status;
            out_q.pad               <= 1'b0;
            out_q.entry_index       <= 9'(res_index);
            out_q.hits              <= res_hits;
            out_q.best_signal       <= res_best;
            out_q.total_devices     <= 10'(used_entries);
            out_q.wifi_devices      <= 10'(wifi_total);
            out_q.ble_devices       <= 10'(used_entries - wifi_total);
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = out_q;
  assign m_tuser = out_status;

  a_counts_ordered: assert property (@(posedge clk) disable iff (rst)
    (wifi_total <= used_entries) && (used_entries <= CNT_W'(TABLE_DEPTH)))
    else $error("device counts out of order");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result raised outside the finishing step");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_CLEARED)) |-> (m_tdata[42:33] == 10'd0))
    else $error("clear result reports stored devices");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !we_rec)
    else $error("table written while idle");

endmodule

`default_nettype wire

// ===== rtl/dot_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module dot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/dot_record_update.sv =====
// Builds the table record written back for an observation: a fresh record on
// insertion or the merged record on a hit. Depends on dot_pkg.
`default_nettype none

module dot_record_update
  import dot_pkg::*;
(
  input  wire logic insert,
  input  wire obs_t obs,
  input  wire rec_t rec_old,
  output rec_t      rec_new
);

  logic [63:0] position;

  assign position = {obs.latitude[30], obs.latitude, obs.longitude};

  always_comb begin
    rec_new = rec_old;
    if (insert) begin
      rec_new.kind_bit  = obs.net_type;
      rec_new.best_rssi = obs.rssi;
      rec_new.last_rssi = obs.rssi;
      rec_new.channel   = obs.channel;
      rec_new.auth_mode = obs.encryption;
      rec_new.first_ms  = obs.now_ms;
      rec_new.last_ms   = obs.now_ms;
      rec_new.first_utc = obs.gps_valid ? obs.gps_utc : 32'd0;
      rec_new.hit_count = 16'd1;
      rec_new.has_fix   = obs.gps_valid;
      rec_new.position  = obs.gps_valid ? position : 64'd0;
    end else begin
      rec_new.last_ms   = obs.now_ms;
      rec_new.last_rssi = obs.rssi;
      if (rec_old.hit_count != 16'hFFFF) begin
        rec_new.hit_count = rec_old.hit_count + 16'd1;
      end
      if (obs.channel != 8'd0) begin
        rec_new.channel = obs.channel;
      end
      if ($signed(obs.rssi) > $signed(rec_old.best_rssi)) begin
        rec_new.best_rssi = obs.rssi;
        if (obs.gps_valid) begin
          rec_new.has_fix  = 1'b1;
          rec_new.position = position;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_device_observation_table.sv =====
// Self-checking testbench for device_observation_table: drives observation and clear
// transactions, predicts every result with a model of the device table, and checks them.
// Depends on dot_pkg and the device_observation_table RTL.
module tb_device_observation_table import dot_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    status_t status;
    res_t    fields;
  } table_report_t;

  class device_table_model;
    logic [47:0]       known_mac [TABLE_DEPTH];
    logic [15:0]       hit_count [TABLE_DEPTH];
    logic signed [7:0] best_rssi [TABLE_DEPTH];
    int unsigned       stored;
    int unsigned       wifi_stored;
    table_report_t     pending_reports[$];
    int                errors;

    function new();
      stored = 0;
      wifi_stored = 0;
      errors = 0;
    endfunction

    function void record_observation(logic clear_all, obs_t obs);
      table_report_t rep;
      int slot;
      int i;
      rep.fields = '0;
      slot = -1;
      if (clear_all) begin
        stored = 0;
        wifi_stored = 0;
        rep.status = ST_CLEARED;
      end else begin
        i = 0;
        while (slot < 0 && i < int'(stored)) begin
          if (known_mac[i] == obs.mac) begin
            slot = i;
          end
          i++;
        end
        if (slot >= 0) begin
          if (hit_count[slot] != 16'hFFFF) begin
            hit_count[slot] = hit_count[slot] + 16'd1;
          end
          if ($signed(obs.rssi) > best_rssi[slot]) begin
            best_rssi[slot] = obs.rssi;
          end
          rep.status = ST_UPDATED;
        end else if (stored >= TABLE_DEPTH) begin
          rep.status = ST_REJECTED;
        end else begin
          slot = int'(stored);
          known_mac[slot] = obs.mac;
          hit_count[slot] = 16'd1;
          best_rssi[slot] = obs.rssi;
          stored++;
          if (!obs.net_type) begin
            wifi_stored++;
          end
          rep.status = ST_INSERTED;
        end
        if (rep.status != ST_REJECTED) begin
          rep.fields.entry_index = slot[8:0];
          rep.fields.hits = hit_count[slot];
          rep.fields.best_signal = best_rssi[slot];
        end
      end
      rep.fields.total_devices = stored[9:0];
      rep.fields.wifi_devices = wifi_stored[9:0];
      rep.fields.ble_devices = 10'(stored - wifi_stored);
      pending_reports.insert(pending_reports.size(), rep);
    endfunction

    function void compare(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(logic [63:0] data, logic [1:0] user);
      res_t got;
      table_report_t want;
      got = res_t'(data);
      if (pending_reports.size() == 0) begin
        $error("result transaction arrived with no prediction waiting");
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      compare("status", int'(want.status), int'(user));
      compare("entry_index", int'(want.fields.entry_index), int'(got.entry_index));
      compare("hits", int'(want.fields.hits), int'(got.hits));
      compare("best_signal", int'($signed(want.fields.best_signal)),
              int'($signed(got.best_signal)));
      compare("total_devices", int'(want.fields.total_devices), int'(got.total_devices));
      compare("wifi_devices", int'(want.fields.wifi_devices), int'(got.wifi_devices));
      compare("ble_devices", int'(want.fields.ble_devices), int'(got.ble_devices));
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [207:0] s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [63:0]  m_tdata;
  logic [1:0]   m_tuser;

  bit quiet;
  bit start_holdoff;
  int stall_cycles = 0;

  device_table_model sb;

  device_observation_table u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic obs_t sighting(input logic [47:0] mac, input logic net,
                                    input logic [7:0] rssi, input logic [7:0] chan,
                                    input logic gps);
    obs_t o;
    int lat;
    longint lon;
    o = '0;
    o.mac = mac;
    o.net_type = net;
    o.rssi = rssi;
    o.channel = chan;
    o.encryption = 8'($urandom);
    o.now_ms = $urandom;
    o.gps_valid = gps;
    o.gps_utc = $urandom;
    lat = int'($urandom_range(0, 1800000000)) - 900000000;
    o.latitude = lat[30:0];
    lon = longint'($urandom_range(0, 32'd3600000000)) - 64'sd1800000000;
    o.longitude = lon[31:0];
    return o;
  endfunction

  function automatic obs_t random_sighting(input logic [47:0] mac);
    logic [7:0] chan;
    chan = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
    return sighting(mac, 1'($urandom), 8'($urandom), chan, 1'($urandom));
  endfunction

  function automatic logic [47:0] random_mac();
    return {$urandom, 16'($urandom)};
  endfunction

  task automatic offer(input logic clear_all, input obs_t item);
    while (!quiet && $urandom_range(0, 99) < 22) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= clear_all;
    s_tdata <= item;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic observe(input logic [47:0] mac, input logic net, input logic [7:0] rssi,
                         input logic [7:0] chan, input logic gps);
    offer(1'b0, sighting(mac, net, rssi, chan, gps));
  endtask

  task automatic clear_table();
    offer(1'b1, random_sighting(random_mac()));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.record_observation(s_tuser, obs_t'(s_tdata));
      end
      if (m_tvalid && m_tready) begin
        sb.check_report(m_tdata, m_tuser);
      end
      stall_cycles <= ((s_tvalid && s_tready) || (m_tvalid && m_tready)) ? 0
                      : stall_cycles + 1;
    end
  end

  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (start_holdoff && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= quiet || ($urandom_range(0, 99) >= 22);
      end
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [47:0] mac;
    logic [47:0] pool[$];
    int r;
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tdata = '0;
    quiet = 1'b0;
    start_holdoff = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: address and signal extremes, ties on the best signal, clears.
    clear_table();
    observe(48'h0, 1'b0, 8'h80, 8'd0, 1'b0);
    observe(48'hFFFF_FFFF_FFFF, 1'b1, 8'h7F, 8'hFF, 1'b1);
    observe(48'h0, 1'b1, 8'h80, 8'd6, 1'b1);
    observe(48'h0, 1'b0, 8'h81, 8'd0, 1'b1);
    observe(48'hFFFF_FFFF_FFFF, 1'b0, 8'h7F, 8'd0, 1'b0);
    observe(48'hFFFF_FFFF_FFFF, 1'b1, 8'h00, 8'd11, 1'b1);
    observe(48'h0000_0000_0001, 1'b0, 8'hFF, 8'd1, 1'b0);
    observe(48'h8000_0000_0000, 1'b1, 8'h01, 8'd36, 1'b1);
    observe(48'h7FFF_FFFF_FFFF, 1'b0, 8'hC4, 8'd165, 1'b0);
    observe(48'h0000_0000_0001, 1'b1, 8'h00, 8'd0, 1'b1);
    observe(48'hFFFF_FFFF_FFFE, 1'b1, 8'h80, 8'd255, 1'b0);
    clear_table();
    observe(48'h8000_0000_0000, 1'b0, 8'h7F, 8'd1, 1'b1);
    observe(48'h0, 1'b1, 8'h80, 8'd0, 1'b0);
    observe(48'h0, 1'b0, 8'h7F, 8'd14, 1'b1);
    clear_table();
    clear_table();

    // Repeated sightings of one device, run back to back with no idling on either side.
    quiet = 1'b1;
    mac = random_mac();
    repeat (30) offer(1'b0, random_sighting(mac));
    quiet = 1'b0;

    // Fill the table past capacity so that new devices are rejected.
    clear_table();
    for (int n = 0; n < 600; n++) begin
      if (n == 300) begin
        start_holdoff = 1'b1;
      end
      if (pool.size() == 0 || $urandom_range(0, 99) < 90) begin
        mac = random_mac();
        pool.insert(pool.size(), mac);
      end else begin
        mac = pool[$urandom_range(0, pool.size() - 1)];
      end
      offer(1'b0, random_sighting(mac));
    end

    // Small tables with frequent revisits and occasional clears.
    clear_table();
    pool.delete();
    repeat (60) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        clear_table();
        pool.delete();
      end else begin
        if (pool.size() == 0 || r < 35) begin
          mac = random_mac();
          pool.insert(pool.size(), mac);
        end else begin
          mac = pool[$urandom_range(0, pool.size() - 1)];
        end
        offer(1'b0, random_sighting(mac));
      end
    end
    s_tvalid <= 1'b0;
    @(posedge clk);

    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
